FILE: rtl/core/vccc_pkg.sv
// Shared constants and types for the voxel cube corner coder.
package vccc_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int COL_W   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SLICE_W = 16;
    localparam int DIM_W   = 7;
    localparam int SLICE_ADDR_W = ROW_W + COL_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int CODE_W = 8;

    localparam logic [DIM_W-1:0]   DIM_RESET   = DIM_W'(64);
    localparam logic [SLICE_W-1:0] DEPTH_RESET = SLICE_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_GRID_DEPTH  = 2'd2
    } t_cfg_reg;

    // Row buffer entry: voxel one row back in this slice and in the previous slice.
    typedef struct packed {
        logic cur_slice;
        logic prev_slice;
    } t_row_entry;

endpackage

FILE: rtl/core/vccc_if.sv
// Channel interfaces: voxel input, cube output and configuration write.
interface vccc_voxel_if;
    logic valid;
    logic ready;
    logic voxel_bit;
    modport source (output valid, output voxel_bit, input ready);
    modport sink   (input valid, input voxel_bit, output ready);
endinterface

interface vccc_cube_if import vccc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] cube_code;
    logic              cube_last;
    modport source (output valid, output cube_code, output cube_last, input ready);
    modport sink   (input valid, input cube_code, input cube_last, output ready);
endinterface

interface vccc_cfg_if import vccc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/vccc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module vccc_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/voxel_cube_corner_code.sv
// Voxel cube corner coder: streams occupancy bits, emits marching-cubes corner codes.
//
// Usage:
//   i_voxel  - one occupancy bit per transaction, raster order (x, then y, then z).
//   o_cube   - one 8-bit corner code per voxel with x, y and z all at least 1,
//              cube_last set on the cube ending at the final voxel of the volume.
//   i_cfg    - register writes (0 width, 1 height, 2 depth); always ready, to be
//              written only while the block is idle. Any write to a known index
//              restarts the volume at (0,0,0). Unknown indices are ignored.
// Throughput: one voxel per cycle while o_cube is not held.
// Pipeline: the history RAMs are read at the edge that accepts a voxel, and its code
//   is loaded into the output register from stage 1 once that register is free.
// State: a slice RAM (one bit per x,y) and a row RAM (two bits per x) are read
//   at acceptance and written back as the voxel leaves stage 1; row length of at
//   least two keeps a read and the pending write of the same entry apart.
// Reset: counters return to (0,0,0), registers to 64/64/64, pipeline empties.
//   RAM contents are not cleared; every entry feeding a code is written first.
// Stall: while o_cube is held, voxels keep entering until one with a code waits
//   behind the output register; i_voxel.ready then drops until o_cube is taken.
module voxel_cube_corner_code import vccc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vccc_voxel_if.sink       i_voxel,
    vccc_cube_if.source      o_cube,
    vccc_cfg_if.sink         i_cfg
);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v < DIM_W'(2)) begin
            res = DIM_W'(2);
        end else if (int'(v) > hi) begin
            res = DIM_W'(hi);
        end
        return res;
    endfunction

    localparam int CMP_W = (DIM_W > COL_W ? DIM_W : COL_W) + 1;
    localparam int RCMP_W = (DIM_W > ROW_W ? DIM_W : ROW_W) + 1;
    localparam int RAM_ROW_W = $bits(t_row_entry);

    // configuration
    logic [DIM_W-1:0]   r_width, r_height;
    logic [SLICE_W-1:0] r_depth;
    logic               cfg_hit;

    // position
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [SLICE_W-1:0] r_slice, n_slice;
    logic               col_end, row_end, slice_end;

    // pipeline
    logic                    in_go;
    logic                    r_s1_valid, r_s1_emit, r_s1_last, r_s1_bit;
    logic [COL_W-1:0]        r_s1_col;
    logic [SLICE_ADDR_W-1:0] r_s1_addr;
    logic                    s1_go, out_free, out_load;

    // previous voxel of the row
    logic       r_prev_bit, r_prev_slice;
    t_row_entry r_prev_row;

    logic       slice_rd;
    t_row_entry row_rd;
    logic [RAM_ROW_W-1:0] row_rd_raw;

    logic                r_out_valid, n_out_valid;
    logic [CODE_W-1:0]   r_out_code, n_code;
    logic                r_out_last;

    assign i_cfg.ready = 1'b1;
    assign cfg_hit = i_cfg.valid && (i_cfg.index == REG_GRID_WIDTH ||
                     i_cfg.index == REG_GRID_HEIGHT || i_cfg.index == REG_GRID_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
            r_depth  <= DEPTH_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_GRID_WIDTH:  r_width  <= clamp_dim(i_cfg.data[DIM_W-1:0], MAX_WIDTH);
                REG_GRID_HEIGHT: r_height <= clamp_dim(i_cfg.data[DIM_W-1:0], MAX_HEIGHT);
                REG_GRID_DEPTH:  r_depth  <= (i_cfg.data < SLICE_W'(2)) ?
                                             SLICE_W'(2) : i_cfg.data;
                default: ;
            endcase
        end
    end

    // handshake
    assign out_free   = !r_out_valid || o_cube.ready;
    assign s1_go      = !r_s1_valid || !r_s1_emit || out_free;
    assign i_voxel.ready = s1_go;
    assign in_go      = i_voxel.valid && s1_go;
    assign out_load   = r_s1_valid && r_s1_emit && out_free;

    // position counters
    assign col_end   = CMP_W'(r_col) + CMP_W'(1) == CMP_W'(r_width);
    assign row_end   = RCMP_W'(r_row) + RCMP_W'(1) == RCMP_W'(r_height);
    assign slice_end = r_slice == r_depth - SLICE_W'(1);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_slice = r_slice;
        if (in_go) begin
            n_col = r_col + COL_W'(1);
            if (col_end) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
                if (row_end) begin
                    n_row   = '0;
                    n_slice = slice_end ? '0 : r_slice + SLICE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col   <= '0;
            r_row   <= '0;
            r_slice <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_slice <= n_slice;
        end
    end

    // stage 1: history read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_go) begin
            r_s1_valid <= in_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_emit <= (r_col != '0) && (r_row != '0) && (r_slice != '0);
            r_s1_last <= col_end && row_end && slice_end;
            r_s1_bit  <= i_voxel.voxel_bit;
            r_s1_col  <= r_col;
            r_s1_addr <= {r_row, r_col};
        end
    end

    vccc_ram #(.ADDR_W(SLICE_ADDR_W), .DATA_W(1)) u_slice_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid && s1_go),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_bit),
        .i_re    (in_go),
        .i_raddr ({r_row, r_col}),
        .o_rdata (slice_rd)
    );

    vccc_ram #(.ADDR_W(COL_W), .DATA_W(RAM_ROW_W)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid && s1_go),
        .i_waddr (r_s1_col),
        .i_wdata ({r_s1_bit, slice_rd}),
        .i_re    (in_go),
        .i_raddr (r_col),
        .o_rdata (row_rd_raw)
    );

    assign row_rd = t_row_entry'(row_rd_raw);

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_go) begin
            r_prev_bit   <= r_s1_bit;
            r_prev_slice <= slice_rd;
            r_prev_row   <= row_rd;
        end
    end

    always_comb begin
        n_code = {r_prev_row.cur_slice, row_rd.cur_slice, row_rd.prev_slice,
                  r_prev_row.prev_slice, r_prev_bit, r_s1_bit, slice_rd, r_prev_slice};
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_cube.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_code <= n_code;
            r_out_last <= r_s1_last;
        end
    end

    assign o_cube.valid     = r_out_valid;
    assign o_cube.cube_code = r_out_code;
    assign o_cube.cube_last = r_out_last;

endmodule

FILE: rtl/core/vccc_checker.sv
// Port-level checks for the voxel cube corner coder, bound to the top level.
module vccc_port_checker import vccc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CODE_W-1:0] i_out_code,
    input logic              i_out_last,
    input logic              i_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_code) &&
        $stable(i_out_last))
        else $error("stalled cube transaction changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("cube output valid straight after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config channel not ready");

    a_first_out_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("cube emitted without a voxel two cycles earlier");

endmodule

bind voxel_cube_corner_code vccc_port_checker u_vccc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_voxel.valid),
    .i_in_ready  (i_voxel.ready),
    .i_out_valid (o_cube.valid),
    .i_out_ready (o_cube.ready),
    .i_out_code  (o_cube.cube_code),
    .i_out_last  (o_cube.cube_last),
    .i_cfg_ready (i_cfg.ready)
);
